FILE: hw/rtl/agcc_pkg.sv
// agcc_pkg: shared types, constants and the arctangent table for the
// angular gate crossing counter. No dependencies.

package agcc_pkg;

   // default sizes handed to the top level parameters
   localparam int MAX_CARS_DEF  = 64;
   localparam int MAX_GATES_DEF = 4;

   // fixed field geometry
   localparam int CarIdxW     = 6;
   localparam int CarSpace    = 64;
   localparam int CoordW      = 32;
   localparam int AngW        = 16;
   localparam int CountW      = 32;
   localparam int GateSlots   = 4;
   localparam int CsrIdxW     = 3;

   // cordic geometry
   localparam int CordicSteps = 24;
   localparam int StepW       = 5;
   localparam int Prescale    = 20;
   localparam int DiffW       = CoordW + 1;
   localparam int VecW        = 56;
   localparam int ZW          = 33;
   localparam int AtanW       = 30;

   // word queue between front and back
   localparam int QueueDepth  = 2;

   localparam logic [AngW-1:0] AngPi   = 16'h8000;
   localparam logic [ZW-1:0]   RoundZ  = 33'h000008000;

   // command codes
   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_CLEAR  = 1'b1;

   // register indexes
   localparam logic [CsrIdxW-1:0] CSR_CENTER_X = 3'd0;
   localparam logic [CsrIdxW-1:0] CSR_CENTER_Y = 3'd1;
   localparam logic [CsrIdxW-1:0] CSR_GATES    = 3'd2;
   localparam logic [CsrIdxW-1:0] CSR_GATE0    = 3'd3;
   localparam logic [CsrIdxW-1:0] CSR_GATE1    = 3'd4;
   localparam logic [CsrIdxW-1:0] CSR_GATE2    = 3'd5;
   localparam logic [CsrIdxW-1:0] CSR_GATE3    = 3'd6;

   typedef struct packed {
      logic                     command;
      logic [CarIdxW-1:0]       car_index;
      logic signed [CoordW-1:0] pos_x;
      logic signed [CoordW-1:0] pos_y;
   } agcc_req_type;

   typedef struct packed {
      logic signed [AngW-1:0] car_angle;
      logic [3:0]             crossed_mask;
      logic [CountW-1:0]      count_gate0;
      logic [CountW-1:0]      count_gate1;
      logic [CountW-1:0]      count_gate2;
      logic [CountW-1:0]      count_gate3;
   } agcc_rsp_type;

   // classified word passed from front to back
   typedef struct packed {
      logic                   command;
      logic [CarIdxW-1:0]     car_index;
      logic signed [AngW-1:0] car_angle;
   } agcc_job_type;

   // gate configuration seen by the back end
   typedef struct packed {
      logic [2:0]                           gates_in_use;
      logic [GateSlots-1:0][AngW-1:0]       gate_angle;
   } agcc_gate_cfg_type;

   // atan(2^-i) in units where 2^31 is pi
   function automatic logic [AtanW-1:0] atan_entry(input logic [StepW-1:0] idx);
      logic [AtanW-1:0] val;
      case (idx)
         5'd0:    val = 30'd536870912;
         5'd1:    val = 30'd316933405;
         5'd2:    val = 30'd167458907;
         5'd3:    val = 30'd85004756;
         5'd4:    val = 30'd42667331;
         5'd5:    val = 30'd21354465;
         5'd6:    val = 30'd10680094;
         5'd7:    val = 30'd5340245;
         5'd8:    val = 30'd2670163;
         5'd9:    val = 30'd1335086;
         5'd10:   val = 30'd667544;
         5'd11:   val = 30'd333772;
         5'd12:   val = 30'd166886;
         5'd13:   val = 30'd83443;
         5'd14:   val = 30'd41721;
         5'd15:   val = 30'd20860;
         5'd16:   val = 30'd10430;
         5'd17:   val = 30'd5215;
         5'd18:   val = 30'd2607;
         5'd19:   val = 30'd1303;
         5'd20:   val = 30'd651;
         5'd21:   val = 30'd325;
         5'd22:   val = 30'd162;
         5'd23:   val = 30'd81;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

FILE: hw/rtl/agcc_front.sv
// agcc_front: accepts request words, runs the iterative cordic atan2 and
// pushes classified words into the queue. Depends on agcc_pkg.

module agcc_front
   import agcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  agcc_req_type             req_data,
   input  logic signed [CoordW-1:0] center_x,
   input  logic signed [CoordW-1:0] center_y,
   output logic                     push_valid,
   input  logic                     push_ready,
   output agcc_job_type             push_data
);

   typedef enum logic [3:0] {
      FS_IDLE = 4'b0001,
      FS_PREP = 4'b0010,
      FS_ITER = 4'b0100,
      FS_PUSH = 4'b1000
   } fstate_type;

   fstate_type               state_ff, state_in;
   logic                     cmd_ff, cmd_in;
   logic [CarIdxW-1:0]       car_ff, car_in;
   logic signed [DiffW-1:0]  dx_ff, dx_in, dy_ff, dy_in;
   logic signed [VecW-1:0]   x_ff, x_in, y_ff, y_in;
   logic signed [ZW-1:0]     z_ff, z_in;
   logic [StepW-1:0]         step_ff, step_in;
   logic                     neg_ff, neg_in;
   logic                     zero_ff, zero_in;

   logic signed [VecW-1:0]   xs, ys;
   logic signed [ZW-1:0]     atan_val;
   logic signed [DiffW-1:0]  ax, ay;
   logic [ZW-1:0]            rnd;

   always_comb begin
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      car_in     = car_ff;
      dx_in      = dx_ff;
      dy_in      = dy_ff;
      x_in       = x_ff;
      y_in       = y_ff;
      z_in       = z_ff;
      step_in    = step_ff;
      neg_in     = neg_ff;
      zero_in    = zero_ff;
      push_valid = 1'b0;
      xs         = x_ff >>> step_ff;
      ys         = y_ff >>> step_ff;
      atan_val   = signed'({3'b000, atan_entry(step_ff)});
      ax         = neg_ff ? -dx_ff : dx_ff;
      ay         = neg_ff ? -dy_ff : dy_ff;
      if (state_ff == FS_PREP) begin
         ax = dx_ff[DiffW-1] ? -dx_ff : dx_ff;
         ay = dx_ff[DiffW-1] ? -dy_ff : dy_ff;
      end
      unique case (state_ff)
         FS_IDLE: begin
            if (req_valid) begin
               cmd_in  = req_data.command;
               car_in  = req_data.car_index;
               dx_in   = {req_data.pos_x[CoordW-1], req_data.pos_x}
                         - {center_x[CoordW-1], center_x};
               dy_in   = {req_data.pos_y[CoordW-1], req_data.pos_y}
                         - {center_y[CoordW-1], center_y};
               zero_in = 1'b1;
               neg_in  = 1'b0;
               if (req_data.command == CMD_CLEAR) begin
                  state_in = FS_PUSH;
               end else begin
                  state_in = FS_PREP;
               end
            end
         end
         FS_PREP: begin
            // fold left half-plane into the right one, pi added at the end
            zero_in  = (dx_ff == '0) && (dy_ff == '0);
            neg_in   = dx_ff[DiffW-1];
            x_in     = {{(VecW-DiffW-Prescale){ax[DiffW-1]}}, ax, {Prescale{1'b0}}};
            y_in     = {{(VecW-DiffW-Prescale){ay[DiffW-1]}}, ay, {Prescale{1'b0}}};
            z_in     = '0;
            step_in  = '0;
            state_in = FS_ITER;
         end
         FS_ITER: begin
            if (!y_ff[VecW-1]) begin
               x_in = x_ff + ys;
               y_in = y_ff - xs;
               z_in = z_ff + atan_val;
            end else begin
               x_in = x_ff - ys;
               y_in = y_ff + xs;
               z_in = z_ff - atan_val;
            end
            step_in = step_ff + 5'd1;
            if (step_ff == StepW'(CordicSteps - 1)) begin
               state_in = FS_PUSH;
            end
         end
         FS_PUSH: begin
            push_valid = 1'b1;
            if (push_ready) begin
               state_in = FS_IDLE;
            end
         end
         default: begin
            state_in = FS_IDLE;
         end
      endcase
   end

   // round to 16 bits, then add the half-plane offset modulo 2^16
   assign rnd = z_ff + RoundZ;
   assign push_data.command   = cmd_ff;
   assign push_data.car_index = car_ff;
   assign push_data.car_angle = zero_ff ? '0
                                : signed'(rnd[31:16] + (neg_ff ? AngPi : '0));
   assign req_ready = (state_ff == FS_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff  <= cmd_in;
      car_ff  <= car_in;
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      step_ff <= step_in;
      neg_ff  <= neg_in;
      zero_ff <= zero_in;
   end

endmodule

FILE: hw/rtl/agcc_queue.sv
// agcc_queue: short word queue between front and back ends.
// Depends on agcc_pkg.

module agcc_queue
   import agcc_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   output logic         push_ready,
   input  agcc_job_type push_data,
   output logic         pop_valid,
   input  logic         pop_ready,
   output agcc_job_type pop_data
);

   localparam int QueueAw = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;

   agcc_job_type          slot_ff [QueueDepth];
   logic [QueueAw-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [QueueAw-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [QueueAw:0]      fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign push_ready = (fill_ff != (QueueAw+1)'(QueueDepth));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QueueAw'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QueueAw'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/agcc_back.sv
// agcc_back: per-car last angle memory, gate compares, saturating counts
// and the result register. Depends on agcc_pkg.

module agcc_back
   import agcc_pkg::*;
#(
   parameter int MAX_CARS  = MAX_CARS_DEF,
   parameter int MAX_GATES = MAX_GATES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  agcc_job_type      pop_data,
   input  agcc_gate_cfg_type gate_cfg,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output agcc_rsp_type      rsp_data
);

   localparam int CarDepth = (MAX_CARS < CarSpace) ? MAX_CARS : CarSpace;
   localparam int CarAw    = (CarDepth > 1) ? $clog2(CarDepth) : 1;

   typedef enum logic [1:0] {
      BS_IDLE = 2'b01,
      BS_EXEC = 2'b10
   } bstate_type;

   bstate_type             state_ff, state_in;
   agcc_job_type           job_ff;
   logic [AngW-1:0]        last_angle_mem [CarDepth];
   logic [CarDepth-1:0]    car_valid_ff;
   logic [AngW-1:0]        rd_angle_ff;
   logic                   rd_valid_ff;
   logic [CountW-1:0]      count_ff [MAX_GATES];
   logic [CountW-1:0]      count_in [MAX_GATES];
   logic                   rsp_valid_ff, rsp_valid_in;
   agcc_rsp_type           rsp_data_ff, rsp_data_in;

   logic                   do_pop;
   logic                   job_in_range;
   logic                   job_sample;
   logic                   mem_write;
   logic [CarAw-1:0]       pop_addr, job_addr;
   logic signed [AngW-1:0] prev_angle;
   logic [3:0]             hit;
   logic [CountW-1:0]      count_out [GateSlots];

   assign pop_ready    = (state_ff == BS_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign do_pop       = pop_valid && pop_ready;
   assign pop_addr     = pop_data.car_index[CarAw-1:0];
   assign job_addr     = job_ff.car_index[CarAw-1:0];
   assign job_sample   = (job_ff.command == CMD_SAMPLE);
   assign job_in_range = ({1'b0, job_ff.car_index} < 7'(CarDepth));
   assign prev_angle   = rd_valid_ff ? signed'(rd_angle_ff) : '0;
   assign mem_write    = (state_ff == BS_EXEC) && job_sample && job_in_range;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      hit          = '0;
      for (int g = 0; g < MAX_GATES; g++) begin
         count_in[g] = count_ff[g];
      end
      for (int g = 0; g < GateSlots; g++) begin
         count_out[g] = '0;
      end
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      unique case (state_ff)
         BS_IDLE: begin
            if (do_pop) begin
               state_in = BS_EXEC;
            end
         end
         BS_EXEC: begin
            for (int g = 0; g < MAX_GATES; g++) begin
               if (!job_sample) begin
                  count_in[g] = '0;
               end else if (job_in_range && (3'(g) < gate_cfg.gates_in_use)
                            && (prev_angle < signed'(gate_cfg.gate_angle[g]))
                            && (job_ff.car_angle >= signed'(gate_cfg.gate_angle[g])))
               begin
                  hit[g] = 1'b1;
                  if (count_ff[g] != '1) begin
                     count_in[g] = count_ff[g] + 1'b1;
                  end
               end
            end
            for (int g = 0; g < MAX_GATES; g++) begin
               count_out[g] = count_in[g];
            end
            rsp_data_in.car_angle    = job_sample ? job_ff.car_angle : '0;
            rsp_data_in.crossed_mask = hit;
            rsp_data_in.count_gate0  = count_out[0];
            rsp_data_in.count_gate1  = count_out[1];
            rsp_data_in.count_gate2  = count_out[2];
            rsp_data_in.count_gate3  = count_out[3];
            rsp_valid_in             = 1'b1;
            state_in                 = BS_IDLE;
         end
         default: begin
            state_in = BS_IDLE;
         end
      endcase
   end

   // last angle store, registered read
   always_ff @(posedge clock) begin
      if (do_pop) begin
         rd_angle_ff <= last_angle_mem[pop_addr];
      end
      if (mem_write) begin
         last_angle_mem[job_addr] <= job_ff.car_angle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BS_IDLE;
         car_valid_ff <= '0;
         rsp_valid_ff <= 1'b0;
         for (int g = 0; g < MAX_GATES; g++) begin
            count_ff[g] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int g = 0; g < MAX_GATES; g++) begin
            count_ff[g] <= count_in[g];
         end
         if (mem_write) begin
            car_valid_ff[job_addr] <= 1'b1;
         end
      end
      if (do_pop) begin
         job_ff      <= pop_data;
         rd_valid_ff <= car_valid_ff[pop_addr];
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hw/rtl/angular_gate_crossing_counter_unit.sv
// angular_gate_crossing_counter_unit: top level with the register file,
// front end, word queue and back end. Depends on agcc_pkg, agcc_front,
// agcc_queue and agcc_back.

// Each request word is either a position sample of one car or a command that
// clears all gate counts, and each gives exactly one response word. A sample
// has its polar angle around the center register taken by a cordic atan2
// (16-bit binary angle, 32768 is pi, pi itself wraps to -32768); every gate in
// use whose angle the car's previous angle was below and the new angle is at
// or above counts one crossing, saturating at all ones. The front end takes a
// sample in steps: it forms the offsets from the center, folds the vector into
// the right half-plane and scales it, runs 24 shift-add iterations of the one
// cordic unit, then rounds and hands the word to the queue; a clear command
// skips the fold and the iterations. A new request is taken only once the last
// word is queued. The back end reads the last-angle memory, then compares and
// counts, and overlaps with the next cordic run through a two-word queue, and
// the response register lets a new request be taken while a response waits.
// The user must write configuration only while the block holds no word in
// flight; the block does not enforce this. Car indexes at or above MAX_CARS
// still return the angle, but cross nothing and leave the state alone.

module angular_gate_crossing_counter_unit
   import agcc_pkg::*;
#(
   parameter int MAX_CARS  = MAX_CARS_DEF,
   parameter int MAX_GATES = MAX_GATES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  agcc_req_type       req_data,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output agcc_rsp_type       rsp_data,
   // register write port
   input  logic               csr_write_en,
   input  logic [CsrIdxW-1:0] csr_index,
   input  logic [CoordW-1:0]  csr_wdata
);

   // configuration registers
   logic signed [CoordW-1:0] center_x_ff;
   logic signed [CoordW-1:0] center_y_ff;
   agcc_gate_cfg_type        gate_cfg_ff;

   // front to queue and queue to back
   logic         push_valid;
   logic         push_ready;
   agcc_job_type push_data;
   logic         pop_valid;
   logic         pop_ready;
   agcc_job_type pop_data;

   // register decode, unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff <= '0;
         center_y_ff <= '0;
         gate_cfg_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_CENTER_X: center_x_ff <= signed'(csr_wdata);
            CSR_CENTER_Y: center_y_ff <= signed'(csr_wdata);
            CSR_GATES:    gate_cfg_ff.gates_in_use  <= csr_wdata[2:0];
            CSR_GATE0:    gate_cfg_ff.gate_angle[0] <= csr_wdata[AngW-1:0];
            CSR_GATE1:    gate_cfg_ff.gate_angle[1] <= csr_wdata[AngW-1:0];
            CSR_GATE2:    gate_cfg_ff.gate_angle[2] <= csr_wdata[AngW-1:0];
            CSR_GATE3:    gate_cfg_ff.gate_angle[3] <= csr_wdata[AngW-1:0];
            default: begin
            end
         endcase
      end
   end

   // front end: offsets, cordic atan2, classification
   agcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .center_x   (center_x_ff),
      .center_y   (center_y_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   // two-word decoupling queue
   agcc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back end: per-car history, gate compares, counts, response register
   agcc_back #(
      .MAX_CARS  (MAX_CARS),
      .MAX_GATES (MAX_GATES)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .gate_cfg  (gate_cfg_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
